@@ rtl/core/crcfr_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package crcfr_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic RESULT_PAYLOAD   = 1'b0;
  localparam logic RESULT_FRAME_END = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CRC_FAIL = 1'b1;

  typedef enum logic [3:0] {
    PH_TYPE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic [7:0]  msg_type;
    logic [31:0] msg_length;
    logic        frame_status;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
  } result_t;

  // Reflected CRC-32, one byte, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/crcfr_parser.sv @@
// Frame parser: header/trailer state, payload counter and running CRC.
// Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                res_push,
  output crcfr_pkg::result_t  res
);

  crcfr_pkg::phase_t phase, phase_next;
  logic [1:0]  field_byte_count, field_byte_count_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] payload_count, payload_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] trailer_crc, trailer_crc_next;
  logic [31:0] comp;

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    frame_type_next       = frame_type;
    frame_length_next     = frame_length;
    payload_count_next    = payload_count;
    running_crc_next      = running_crc;
    trailer_crc_next      = trailer_crc;
    res_push              = 1'b0;
    res                   = '0;
    comp                  = ~running_crc;
    case (phase)
      crcfr_pkg::PH_TYPE: begin
        frame_type_next       = rx_byte;
        frame_length_next     = '0;
        field_byte_count_next = '0;
        phase_next            = crcfr_pkg::PH_LEN;
      end
      crcfr_pkg::PH_LEN: begin
        frame_length_next     = {rx_byte, frame_length[31:8]};
        field_byte_count_next = field_byte_count + 2'd1;
        if (field_byte_count == 2'd3) begin
          payload_count_next = '0;
          running_crc_next   = crcfr_pkg::CRC_INIT;
          trailer_crc_next   = '0;
          phase_next = (frame_length_next == 32'd0) ? crcfr_pkg::PH_CRC : crcfr_pkg::PH_DATA;
        end
      end
      crcfr_pkg::PH_DATA: begin
        res_push           = 1'b1;
        res.result_kind    = crcfr_pkg::RESULT_PAYLOAD;
        res.payload_byte   = rx_byte;
        res.payload_index  = payload_count;
        res.msg_type       = frame_type;
        res.msg_length     = frame_length;
        running_crc_next   = crcfr_pkg::crc_byte(running_crc, rx_byte);
        payload_count_next = payload_count + 32'd1;
        if (payload_count_next == frame_length) begin
          field_byte_count_next = '0;
          phase_next            = crcfr_pkg::PH_CRC;
        end
      end
      default: begin
        trailer_crc_next      = {rx_byte, trailer_crc[31:8]};
        field_byte_count_next = field_byte_count + 2'd1;
        if (field_byte_count == 2'd3) begin
          res_push          = 1'b1;
          res.result_kind   = crcfr_pkg::RESULT_FRAME_END;
          res.payload_index = payload_count;
          res.msg_type      = frame_type;
          res.msg_length    = frame_length;
          res.frame_status  = (trailer_crc_next != comp) ? crcfr_pkg::STATUS_CRC_FAIL
                                                         : crcfr_pkg::STATUS_OK;
          res.received_crc  = trailer_crc_next;
          res.computed_crc  = comp;
          phase_next            = crcfr_pkg::PH_TYPE;
          field_byte_count_next = '0;
          payload_count_next    = '0;
          running_crc_next      = crcfr_pkg::CRC_INIT;
          trailer_crc_next      = '0;
        end
      end
    endcase
    if (!accept) begin
      res_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= crcfr_pkg::PH_TYPE;
      field_byte_count <= '0;
      frame_type       <= '0;
      frame_length     <= '0;
      payload_count    <= '0;
      running_crc      <= crcfr_pkg::CRC_INIT;
      trailer_crc      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      frame_type       <= frame_type_next;
      frame_length     <= frame_length_next;
      payload_count    <= payload_count_next;
      running_crc      <= running_crc_next;
      trailer_crc      <= trailer_crc_next;
    end
  end

endmodule

@@ rtl/core/crcfr_out_buf.sv @@
// Two-word result buffer between the parser and the output channel.
// Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crcfr_pkg::result_t  push_data,
  input  logic                pop_stall,
  output logic                full,
  output logic                out_valid,
  output crcfr_pkg::result_t  out_data
);

  crcfr_pkg::result_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !pop_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/crc32_frame_receiver.sv @@
// Top level of the CRC-32 frame receiver: parser plus result buffer.
// Depends on crcfr_pkg, crcfr_parser and crcfr_out_buf.
`timescale 1ns / 1ps

// Usage:
//   Input channel: one received byte per word on rx_byte, in_valid/in_stall.
//   Frames are a type byte, a 4-byte little-endian length, the payload and a
//   4-byte little-endian CRC-32 (zlib) over the payload.
//   Output channel: out_valid/out_stall with one word per payload byte
//   (result_kind 0) and one frame-end word (result_kind 1) after the last
//   trailer byte carrying type, length, both CRCs and frame_status.
//   Header bytes and the first three trailer bytes give no output word.
//   Throughput: one input byte per cycle while in_stall is low, set by the byte-wide
//   CRC update and header/trailer shift registers.
//   Results: a result word is registered into the output buffer when its byte
//   is accepted, and is shown once the words ahead of it are taken.
//   Output stall: results collect in a two-word buffer; in_stall rises only
//   when both words are held, and drops as soon as one is taken.
//   Reset: synchronous; the parser waits for a type byte with a fresh CRC and
//   the output buffer is empty. There is no resynchronization: every byte is
//   taken as the next byte of the frame format.

module crc32_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [31:0] payload_index,
  output logic [7:0]  msg_type,
  output logic [31:0] msg_length,
  output logic        frame_status,
  output logic [31:0] received_crc,
  output logic [31:0] computed_crc
);

  logic               accept;
  logic               res_push;
  logic               buf_full;
  crcfr_pkg::result_t res;
  crcfr_pkg::result_t out_word;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  crcfr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .res_push (res_push),
    .res      (res)
  );

  crcfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop_stall (out_stall),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_data  (out_word)
  );

  assign result_kind   = out_word.result_kind;
  assign payload_byte  = out_word.payload_byte;
  assign payload_index = out_word.payload_index;
  assign msg_type      = out_word.msg_type;
  assign msg_length    = out_word.msg_length;
  assign frame_status  = out_word.frame_status;
  assign received_crc  = out_word.received_crc;
  assign computed_crc  = out_word.computed_crc;

  a_end_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == crcfr_pkg::RESULT_FRAME_END) |-> payload_index == msg_length)
    else $error("frame end payload count differs from length");

  a_end_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == crcfr_pkg::RESULT_FRAME_END)
      |-> (frame_status == (received_crc != computed_crc)) && payload_byte == 8'd0)
    else $error("frame end status inconsistent with CRCs");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == crcfr_pkg::RESULT_PAYLOAD)
      |-> frame_status == crcfr_pkg::STATUS_OK && received_crc == 32'd0
          && computed_crc == 32'd0 && payload_index < msg_length)
    else $error("payload word carries frame end fields");

  a_reset_ready: assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("buffer not empty after reset");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for crc32_frame_receiver: directed frames from a table, then random
// frames with good and bad CRCs, checked against a byte-level frame parser and CRC-32 model.
// Depends on crcfr_pkg and the crc32_frame_receiver RTL.
`timescale 1ns / 1ps

module tb;
  import crcfr_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0] rx;
    bit         fixed;
    result_t    res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [31:0] payload_index;
  logic [7:0]  msg_type;
  logic [31:0] msg_length;
  logic        frame_status;
  logic [31:0] received_crc;
  logic [31:0] computed_crc;

  crc32_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .msg_type(msg_type),
    .msg_length(msg_length),
    .frame_status(frame_status),
    .received_crc(received_crc),
    .computed_crc(computed_crc)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state
  phase_t      rx_phase   = PH_TYPE;
  logic [1:0]  field_cnt  = 2'd0;
  logic [7:0]  cur_type   = 8'h00;
  logic [31:0] cur_len    = 32'd0;
  logic [31:0] pay_cnt    = 32'd0;
  logic [31:0] crc_reg    = CRC_INIT;
  logic [31:0] trailer    = 32'd0;

  result_t     pending_results[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] v;
    logic        fb;
    v = c;
    for (int i = 0; i < 8; i++) begin
      fb = v[0] ^ d[i];
      v = (v >> 1) ^ (fb ? CRC_POLY : 32'd0);
    end
    return v;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, output bit has, output result_t r);
    has = 1'b0;
    r = '0;
    case (rx_phase)
      PH_TYPE: begin
        cur_type = b;
        cur_len = 32'd0;
        field_cnt = 2'd0;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        cur_len = {b, cur_len[31:8]};
        field_cnt = field_cnt + 2'd1;
        if (field_cnt == 2'd0) begin
          pay_cnt = 32'd0;
          crc_reg = CRC_INIT;
          trailer = 32'd0;
          rx_phase = (cur_len == 32'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        has = 1'b1;
        r.result_kind = RESULT_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = pay_cnt;
        r.msg_type = cur_type;
        r.msg_length = cur_len;
        crc_reg = crc32_shift(crc_reg, b);
        pay_cnt = pay_cnt + 32'd1;
        if (pay_cnt == cur_len) begin
          field_cnt = 2'd0;
          rx_phase = PH_CRC;
        end
      end
      default: begin
        trailer = {b, trailer[31:8]};
        field_cnt = field_cnt + 2'd1;
        if (field_cnt == 2'd0) begin
          has = 1'b1;
          r.result_kind = RESULT_FRAME_END;
          r.payload_index = pay_cnt;
          r.msg_type = cur_type;
          r.msg_length = cur_len;
          r.frame_status = (trailer != ~crc_reg) ? STATUS_CRC_FAIL : STATUS_OK;
          r.received_crc = trailer;
          r.computed_crc = ~crc_reg;
          rx_phase = PH_TYPE;
          pay_cnt = 32'd0;
          crc_reg = CRC_INIT;
          trailer = 32'd0;
        end
      end
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t hdr(input logic [7:0] b);
    stim_row_t row;
    row.rx = b;
    row.fixed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic stim_row_t pay_row(input logic [7:0] b, input logic [31:0] idx,
                                        input logic [7:0] typ, input logic [31:0] len);
    stim_row_t row;
    row = hdr(b);
    row.fixed = 1'b1;
    row.res.result_kind = RESULT_PAYLOAD;
    row.res.payload_byte = b;
    row.res.payload_index = idx;
    row.res.msg_type = typ;
    row.res.msg_length = len;
    return row;
  endfunction

  function automatic stim_row_t end_row(input logic [7:0] b, input logic [7:0] typ,
                                        input logic [31:0] len, input logic status,
                                        input logic [31:0] recv, input logic [31:0] comp);
    stim_row_t row;
    row = hdr(b);
    row.fixed = 1'b1;
    row.res.result_kind = RESULT_FRAME_END;
    row.res.payload_index = len;
    row.res.msg_type = typ;
    row.res.msg_length = len;
    row.res.frame_status = status;
    row.res.received_crc = recv;
    row.res.computed_crc = comp;
    return row;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit fixed, input result_t fres);
    int      gap;
    bit      has;
    result_t r;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, has, r);
    if (fixed) pending_results.push_back(fres);
    else if (has) pending_results.push_back(r);
    words_sent++;
  endtask

  // body < len leaves the frame open (no trailer)
  task automatic send_frame(input logic [7:0] typ, input logic [31:0] len,
                            input logic [31:0] body, input bit bad);
    logic [31:0] acc;
    logic [31:0] trl;
    logic [7:0]  d;
    result_t     none;
    int          r;
    none = '0;
    send_byte(typ, 1'b0, none);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8], 1'b0, none);
    acc = CRC_INIT;
    for (logic [31:0] i = 0; i < body; i++) begin
      r = $urandom_range(0, 9);
      d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      acc = crc32_shift(acc, d);
      send_byte(d, 1'b0, none);
    end
    if (body == len) begin
      trl = ~acc;
      if (bad) trl = ($urandom_range(0, 1) == 1) ? (trl ^ (32'd1 << $urandom_range(0, 31)))
                                                 : 32'($urandom);
      for (int i = 0; i < 4; i++) send_byte(trl[8*i +: 8], 1'b0, none);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  int stall_left = 0;
  int run_left = 0;

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word expected none actual kind %0b index %h", $time,
                 result_kind, payload_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("result_kind", 32'(want.result_kind), 32'(result_kind));
        cmp_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
        cmp_field("payload_index", want.payload_index, payload_index);
        cmp_field("msg_type", 32'(want.msg_type), 32'(msg_type));
        cmp_field("msg_length", want.msg_length, msg_length);
        cmp_field("frame_status", 32'(want.frame_status), 32'(frame_status));
        cmp_field("received_crc", want.received_crc, received_crc);
        cmp_field("computed_crc", want.computed_crc, computed_crc);
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
      stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   tab[$];
    logic [31:0] len;
    int          r;
    // zero length, all-zero trailer: CRC match
    tab.push_back(hdr(8'h00));
    repeat (4) tab.push_back(hdr(8'h00));
    repeat (3) tab.push_back(hdr(8'h00));
    tab.push_back(end_row(8'h00, 8'h00, 32'd0, STATUS_OK, 32'd0, 32'd0));
    // zero length, all-ones trailer: CRC mismatch
    tab.push_back(hdr(8'hFF));
    repeat (4) tab.push_back(hdr(8'h00));
    repeat (3) tab.push_back(hdr(8'hFF));
    tab.push_back(end_row(8'hFF, 8'hFF, 32'd0, STATUS_CRC_FAIL, 32'hFFFFFFFF, 32'd0));
    // one payload byte
    tab.push_back(hdr(8'h80));
    tab.push_back(hdr(8'h01));
    repeat (3) tab.push_back(hdr(8'h00));
    tab.push_back(pay_row(8'hFF, 32'd0, 8'h80, 32'd1));
    repeat (3) tab.push_back(hdr(8'h00));
    tab.push_back(hdr(8'hFF));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (tab[i]) send_byte(tab[i].rx, tab[i].fixed, tab[i].res);

    while (words_sent < RANDOM_WORDS + tab.size()) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) len = 32'd0;
      else if (r < 80) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 200);
      send_frame(8'($urandom), len, len, $urandom_range(0, 3) == 0);
    end
    // maximum length field; frame left open at the end of the run
    quiet = 1'b0;
    send_frame(8'($urandom), 32'hFFFFFFFF, 32'd24, 1'b0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_parser.sv
rtl/core/crcfr_out_buf.sv
rtl/core/crc32_frame_receiver.sv
tb/sv/tb.sv
